// ===== design/modular_power_table_unit_macros.svh =====
// Assertion macros for the top-level file of the block.
`ifndef MODULAR_POWER_TABLE_UNIT_MACROS_SVH
`define MODULAR_POWER_TABLE_UNIT_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define MPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpt assertion failed");

// Check the consequent in the cycle after the antecedent.
`define MPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpt assertion failed");

`endif

// ===== design/mpt_pkg.sv =====
package mpt_pkg;

  // Field widths
  localparam int BASE_W = 32;
  localparam int RES_W  = 31;
  localparam int EXP_W  = 6;

  // Highest exponent of a run
  localparam int MAX_EXPONENT = 63;

  // Width of the step counter of the shift-add modular multiplier, one step per multiplier bit
  localparam int STEP_W = $clog2(BASE_W);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [RES_W-1:0] MODULUS_RESET = 31'h7FFF_FFFF;

  typedef enum logic [0:0] {
    REG_MODULUS = 1'b0
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EMIT_ONE,
    ST_REDUCE,
    ST_EMIT,
    ST_MULT
  } state_e;

  // Request to the modular multiplier
  typedef struct packed {
    logic              start;
    logic [RES_W-1:0]  a;
    logic [BASE_W-1:0] x;
  } mul_req_t;

  // Status of the modular multiplier
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [RES_W-1:0] result;
  } mul_rsp_t;

endpackage

// ===== design/mpt_in_if.sv =====
interface mpt_in_if import mpt_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [BASE_W-1:0] base_value;
  logic        [EXP_W-1:0]  exponent_count;

  modport source (output valid, output base_value, output exponent_count, input ready);
  modport sink   (input valid, input base_value, input exponent_count, output ready);
endinterface

// ===== design/mpt_out_if.sv =====
interface mpt_out_if import mpt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [RES_W-1:0] residue;
  logic [EXP_W-1:0] exponent;
  logic             last_of_run;

  modport source (output valid, output residue, output exponent, output last_of_run,
                  input ready);
  modport sink   (input valid, input residue, input exponent, input last_of_run,
                  output ready);
endinterface

// ===== design/mpt_cfg.sv =====
module mpt_cfg import mpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [RES_W-1:0]   modulus_eff_o
);

  logic [RES_W-1:0] modulus_q;
  logic [RES_W-1:0] modulus_d;
  logic             hit_modulus;

  assign pready      = 1'b1;
  assign hit_modulus = (paddr[PADDR_W-1:2] == REG_MODULUS);

  // Write the modulus on the access cycle of a transfer
  always_comb begin
    modulus_d = modulus_q;
    if (psel && penable && pwrite && pready && hit_modulus) begin
      modulus_d = pwdata[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MODULUS_RESET;
    end else begin
      modulus_q <= modulus_d;
    end
  end

  // Read back; unmapped addresses read as zero
  assign prdata = hit_modulus ? {{(PDATA_W-RES_W){1'b0}}, modulus_q} : '0;

  // A zero modulus acts as modulus one
  assign modulus_eff_o = (modulus_q == '0) ? RES_W'(1) : modulus_q;

endmodule

// ===== design/mpt_modmul.sv =====
module mpt_modmul import mpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RES_W-1:0] modulus_i,
  input  mul_req_t         req_i,
  output mul_rsp_t         rsp_o
);

  // Computes (x * a) mod m, one bit of x per cycle, MSB first.
  // Needs acc < m and a <= m + 1 so that one step stays below 3m.
  localparam int T_W = RES_W + 3;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [RES_W-1:0]  acc_q, acc_d;
  logic [BASE_W-1:0] x_q, x_d;
  logic [RES_W-1:0]  a_q, a_d;

  logic [T_W-1:0] t_sum;
  logic [T_W-1:0] t_m1;
  logic [T_W-1:0] t_m2;
  logic [RES_W-1:0] step_res;

  // Double, add, then subtract m or 2m when that stays non-negative
  always_comb begin
    t_sum = {2'b00, acc_q, 1'b0} + (x_q[BASE_W-1] ? {3'b000, a_q} : '0);
    t_m1  = t_sum - {3'b000, modulus_i};
    t_m2  = t_sum - {2'b00, modulus_i, 1'b0};
    if (!t_m2[T_W-1]) begin
      step_res = t_m2[RES_W-1:0];
    end else if (!t_m1[T_W-1]) begin
      step_res = t_m1[RES_W-1:0];
    end else begin
      step_res = t_sum[RES_W-1:0];
    end
  end

  // Sequence the steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    a_d    = a_q;
    if (busy_q) begin
      acc_d = step_res;
      x_d   = {x_q[BASE_W-2:0], 1'b0};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - STEP_W'(1);
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(BASE_W - 1);
      acc_d  = '0;
      x_d    = req_i.x;
      a_d    = req_i.a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    acc_q <= acc_d;
    x_q   <= x_d;
    a_q   <= a_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

// ===== design/mpt_ctrl.sv =====
module mpt_ctrl import mpt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [RES_W-1:0] modulus_i,
  mpt_in_if.sink           in_if,
  mpt_out_if.source        out_if,
  output mul_req_t         mul_req_o,
  input  mul_rsp_t         mul_rsp_i
);

  state_e state_q, state_d;

  logic             out_valid_q, out_valid_d;
  logic [RES_W-1:0] out_res_q, out_res_d;
  logic [EXP_W-1:0] out_exp_q, out_exp_d;
  logic             out_last_q, out_last_d;

  logic [BASE_W-1:0] base_raw_q, base_raw_d;
  logic [EXP_W-1:0]  n_q, n_d;
  logic [RES_W-1:0]  base_res_q, base_res_d;
  logic [RES_W-1:0]  run_q, run_d;
  logic [EXP_W-1:0]  e_q, e_d;

  logic              slot_free;
  logic [BASE_W-1:0] base_mag;
  logic [RES_W-1:0]  base_fix;
  logic [EXP_W-1:0]  n_sat;

  assign slot_free = !out_valid_q || out_if.ready;
  assign base_mag  = base_raw_q[BASE_W-1] ? (~base_raw_q + BASE_W'(1)) : base_raw_q;
  // True modulo of a negative base: m - r unless r is zero
  assign base_fix  = (base_raw_q[BASE_W-1] && (mul_rsp_i.result != '0)) ?
                     (modulus_i - mul_rsp_i.result) : mul_rsp_i.result;
  assign n_sat     = (in_if.exponent_count > EXP_W'(MAX_EXPONENT)) ?
                     EXP_W'(MAX_EXPONENT) : in_if.exponent_count;

  // Next state, datapath updates and output register loads
  always_comb begin
    state_d     = state_q;
    in_if.ready = 1'b0;
    mul_req_o   = '0;
    out_valid_d = out_valid_q && !out_if.ready;
    out_res_d   = out_res_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    base_raw_d  = base_raw_q;
    n_d         = n_q;
    base_res_d  = base_res_q;
    run_d       = run_q;
    e_d         = e_q;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          base_raw_d = in_if.base_value;
          n_d        = n_sat;
          state_d    = ST_EMIT_ONE;
        end
      end
      ST_EMIT_ONE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_res_d   = RES_W'(1);
          out_exp_d   = '0;
          out_last_d  = (n_q == '0);
          if (n_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            // Reduce the base magnitude: mag * 1 mod m
            mul_req_o.start = 1'b1;
            mul_req_o.a     = RES_W'(1);
            mul_req_o.x     = base_mag;
            state_d         = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (mul_rsp_i.done) begin
          base_res_d = base_fix;
          run_d      = base_fix;
          e_d        = EXP_W'(1);
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_res_d   = run_q;
          out_exp_d   = e_q;
          out_last_d  = (e_q == n_q);
          if (e_q == n_q) begin
            state_d = ST_IDLE;
          end else begin
            mul_req_o.start = 1'b1;
            mul_req_o.a     = base_res_q;
            mul_req_o.x     = {1'b0, run_q};
            state_d         = ST_MULT;
          end
        end
      end
      ST_MULT: begin
        if (mul_rsp_i.done) begin
          run_d   = mul_rsp_i.result;
          e_d     = e_q + EXP_W'(1);
          state_d = ST_EMIT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    out_exp_q  <= out_exp_d;
    out_last_q <= out_last_d;
    base_raw_q <= base_raw_d;
    n_q        <= n_d;
    base_res_q <= base_res_d;
    run_q      <= run_d;
    e_q        <= e_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.residue     = out_res_q;
  assign out_if.exponent    = out_exp_q;
  assign out_if.last_of_run = out_last_q;

endmodule

// ===== design/modular_power_table_unit.sv =====
// Modular power table unit.
// Input channel in_i carries a signed base and an exponent count n; one
// transfer starts a run of n+1 result transfers on out_o: base^0 .. base^n,
// each reduced modulo the modulus register, exponent 0 first, the last one
// marked by last_of_run. Exponent 0 always gives residue 1.
// The modulus sits at APB byte address 0 (reset 2^31-1; zero acts as one).
// Write it only while no run is in flight.
// After an input transfer the sequencer loads residue 1 into the output
// register. Each later residue comes from the shared shift-add modular
// multiplier, which retires one multiplier bit per cycle over 32 steps;
// the sequencer then takes its result and loads the output register. The
// first multiplication reduces the base, the others multiply by the base
// residue.
// in_i.ready is high only between runs; a new item can be taken while the
// final result still waits in the output register.
// A stall on out_o holds the output register and holds the sequencer before
// it starts the next multiplication; nothing is lost.
// Reset empties the output register, returns to idle and restores the
// modulus.
`include "modular_power_table_unit_macros.svh"

module modular_power_table_unit import mpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  mpt_in_if.sink             in_i,
  mpt_out_if.source          out_o
);

  logic [RES_W-1:0] modulus_eff;
  mul_req_t         mul_req;
  mul_rsp_t         mul_rsp;

  mpt_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .modulus_eff_o (modulus_eff)
  );

  mpt_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (modulus_eff),
    .req_i     (mul_req),
    .rsp_o     (mul_rsp)
  );

  mpt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (modulus_eff),
    .in_if     (in_i),
    .out_if    (out_o),
    .mul_req_o (mul_req),
    .mul_rsp_i (mul_rsp)
  );

  // An accepted item blocks the input until its run is done
  `MPT_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)

  // Exponent zero always carries residue one
  `MPT_ASSERT_SAME(a_first_is_one, clk_i, rst_ni, out_o.valid && (out_o.exponent == '0),
                   out_o.residue == RES_W'(1))

  // Later residues are fully reduced
  `MPT_ASSERT_SAME(a_residue_reduced, clk_i, rst_ni, out_o.valid && (out_o.exponent != '0),
                   out_o.residue < modulus_eff)

  // The multiplier is never restarted while it runs
  `MPT_ASSERT_SAME(a_no_restart, clk_i, rst_ni, mul_req.start, !mul_rsp.busy)

endmodule

// ===== test/modular_power_table_unit_tb.sv =====
`timescale 1ns / 100ps

module modular_power_table_unit_tb;
  import mpt_pkg::*;

  // First register index past the end of the register map
  localparam int SPARE_REG_IDX = 1;
  // Percentage of cycles in which a side idles
  localparam int IDLE_PCT = 35;
  // Cycles to wait after the last residue before ending the run
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [BASE_W-1:0] base_value;
    logic [EXP_W-1:0]  exponent_count;
  } power_req_t;

  typedef struct packed {
    logic [RES_W-1:0] residue;
    logic [EXP_W-1:0] exponent;
    logic             last_of_run;
  } residue_rec_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mpt_in_if  in_bus ();
  mpt_out_if out_bus ();

  modular_power_table_unit DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_bus),
    .out_o   (out_bus)
  );

  // Shadow of the block: modulus register and run state
  logic [RES_W-1:0] modulus_shadow;
  logic [RES_W-1:0] base_res;
  logic [RES_W-1:0] run_res;
  logic [EXP_W-1:0] exp_ctr;

  power_req_t   pending_powers[$];
  residue_rec_t awaited_residues[$];
  int           queued_count;
  int           taken_count;
  int           mismatch_count;
  logic         base_taken;
  logic         steady;

  // Work out the whole run of residues for one accepted base
  function automatic void predict_powers(input logic [BASE_W-1:0] base_bits,
                                         input logic [EXP_W-1:0]  count);
    logic [63:0]  m;
    logic [63:0]  mag;
    logic [63:0]  r;
    logic [63:0]  prod;
    int unsigned  n;
    residue_rec_t rec;
    m = (modulus_shadow == '0) ? 64'd1 : {33'd0, modulus_shadow};
    n = (count > MAX_EXPONENT) ? MAX_EXPONENT : count;
    // True modulo: a negative base folds back into 0 .. m-1
    if (base_bits[BASE_W-1]) begin
      mag = 64'h1_0000_0000 - {32'd0, base_bits};
      r = mag % m;
      base_res = (r == 64'd0) ? '0 : RES_W'(m - r);
    end else begin
      base_res = RES_W'({32'd0, base_bits} % m);
    end
    run_res = 1;
    exp_ctr = '0;
    rec.residue = 1;
    rec.exponent = '0;
    rec.last_of_run = (n == 0);
    awaited_residues = {awaited_residues, rec};
    for (int unsigned e = 1; e <= n; e++) begin
      if (e == 1) prod = {33'd0, base_res};
      else prod = ({33'd0, run_res} * {33'd0, base_res}) % m;
      run_res = RES_W'(prod);
      exp_ctr = EXP_W'(e);
      rec.residue = run_res;
      rec.exponent = exp_ctr;
      rec.last_of_run = (e == n);
      awaited_residues = {awaited_residues, rec};
    end
  endfunction

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(3))
      0: return BASE_W'($urandom_range(40)) - BASE_W'(20);
      1: begin
        case ($urandom_range(5))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          3: return BASE_W'(modulus_shadow);
          4: return -BASE_W'(modulus_shadow);
          default: return BASE_W'(modulus_shadow) + 1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Mostly short runs, now and then a long one
  function automatic logic [EXP_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 2) return '0;
    if (roll < 70) return EXP_W'($urandom_range(8, 1));
    if (roll < 90) return EXP_W'($urandom_range(31, 9));
    return EXP_W'($urandom_range(MAX_EXPONENT, 32));
  endfunction

  task automatic queue_power(input logic [BASE_W-1:0] base_bits,
                             input logic [EXP_W-1:0]  count);
    power_req_t req;
    req.base_value = base_bits;
    req.exponent_count = count;
    pending_powers = {pending_powers, req};
    queued_count++;
  endtask

  task automatic queue_random(input int num);
    for (int i = 0; i < num; i++) queue_power(pick_base(), pick_count());
  endtask

  // Hold until every queued base is taken and every residue has arrived
  task automatic wait_drained();
    do @(negedge clk_i);
    while (taken_count != queued_count || awaited_residues.size() != 0);
  endtask

  // APB write; called at a falling edge, returns at a falling edge
  task automatic write_reg(input int idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (pready !== 1'b1);
    if (idx == REG_MODULUS) modulus_shadow = value[RES_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive the base channel from the pending queue, stall the residue channel
  always @(negedge clk_i) begin : drive_channels
    power_req_t req;
    if (rst_ni) begin
      if (!in_bus.valid || base_taken) begin
        if (pending_powers.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          req = pending_powers.pop_front();
          in_bus.base_value     <= req.base_value;
          in_bus.exponent_count <= req.exponent_count;
          in_bus.valid          <= 1'b1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
      out_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check residue transfers, then predict runs for accepted bases
  always @(posedge clk_i) begin : check_residues
    residue_rec_t want;
    if (!rst_ni) begin
      base_taken <= 1'b0;
    end else begin
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (awaited_residues.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected residue %0d exponent %0d last %0b", $time,
                   out_bus.residue, out_bus.exponent, out_bus.last_of_run);
        end else begin
          want = awaited_residues.pop_front();
          if (out_bus.residue !== want.residue || out_bus.exponent !== want.exponent ||
              out_bus.last_of_run !== want.last_of_run) begin
            mismatch_count++;
            $display("%0t: expected residue %0d exponent %0d last %0b, got %0d %0d %0b",
                     $time, want.residue, want.exponent, want.last_of_run,
                     out_bus.residue, out_bus.exponent, out_bus.last_of_run);
          end
        end
      end
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1) begin
        predict_powers(in_bus.base_value, in_bus.exponent_count);
        taken_count++;
      end
      base_taken <= (in_bus.valid === 1'b1 && in_bus.ready === 1'b1);
    end
  end

  initial begin
    in_bus.valid          = 1'b0;
    in_bus.base_value     = '0;
    in_bus.exponent_count = '0;
    out_bus.ready         = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    steady                = 1'b0;
    queued_count          = 0;
    taken_count           = 0;
    mismatch_count        = 0;
    modulus_shadow        = MODULUS_RESET;
    base_res              = '0;
    run_res               = '0;
    exp_ctr               = '0;
    rst_ni                = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset modulus: zero, one, extremes of the base, longest run, empty run
    queue_power(32'd0, 6'd1);
    queue_power(32'd1, 6'd63);
    queue_power(32'hFFFF_FFFF, 6'd5);
    queue_power(32'h7FFF_FFFF, 6'd3);
    queue_power(32'h8000_0000, 6'd4);
    queue_power(32'h8000_0001, 6'd2);
    queue_power(32'd2, 6'd63);
    queue_power(32'd12345, 6'd0);
    queue_power(32'hFFFF_FFFE, 6'd2);
    wait_drained();

    // Modulus one: every residue after the first is zero
    write_reg(REG_MODULUS, 32'd1);
    queue_power(32'd5, 6'd3);
    queue_power(-32'sd7, 6'd2);
    queue_power(32'd0, 6'd0);
    wait_drained();

    // Modulus zero acts as one
    write_reg(REG_MODULUS, 32'd0);
    queue_power(32'd9, 6'd2);
    queue_power(-32'sd9, 6'd1);
    wait_drained();

    // Small modulus; a write past the register map must leave it alone
    write_reg(REG_MODULUS, 32'd13);
    write_reg(SPARE_REG_IDX, 32'd5);
    queue_power(-32'sd20, 6'd6);
    queue_power(32'd13, 6'd2);
    queue_power(-32'sd13, 6'd3);
    queue_power(32'd6, 6'd12);
    wait_drained();

    // Top bit of the write data is dropped, leaving the largest modulus
    write_reg(REG_MODULUS, 32'hFFFF_FFFF);
    queue_power(32'hFFFF_FFFF, 6'd4);
    queue_power(32'h7FFF_FFFE, 6'd3);
    queue_power(32'h8000_0000, 6'd2);
    wait_drained();

    // Random phases over a spread of moduli
    write_reg(REG_MODULUS, PDATA_W'($urandom_range(50, 2)));
    queue_random(35);
    wait_drained();

    write_reg(REG_MODULUS, 32'd2);
    queue_random(30);
    wait_drained();

    steady = 1'b1;
    write_reg(REG_MODULUS, PDATA_W'($urandom_range(32'h7FFF_FFFF, 1)));
    queue_random(35);
    wait_drained();
    steady = 1'b0;

    write_reg(REG_MODULUS, 32'h4000_0000);
    queue_random(30);
    wait_drained();

    write_reg(REG_MODULUS, 32'd65521);
    queue_random(35);
    wait_drained();

    write_reg(REG_MODULUS, 32'h7FFF_FFFF);
    queue_random(35);
    wait_drained();

    // Let any stray residue show up before deciding
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/mpt_pkg.sv
design/mpt_in_if.sv
design/mpt_out_if.sv
design/mpt_cfg.sv
design/mpt_modmul.sv
design/mpt_ctrl.sv
design/modular_power_table_unit.sv
test/modular_power_table_unit_tb.sv
